@@ sv/hcr_pkg.sv @@
// package for the hex character reference byte decoder
// holds transaction structs, the front-to-back command record and character helpers
// no dependencies
package hcr_pkg;

   // characters of the escape pattern
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // input transaction
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_end;
   } hcr_req_type;

   // result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_last;
   } hcr_rsp_type;

   // one input byte's work: a prefix of "&#x" d1 d2, then an optional tail byte
   typedef struct packed {
      logic [2:0] pre_cnt;
      logic [7:0] digit1;
      logic [7:0] digit2;
      logic       has_tail;
      logic [7:0] tail;
      logic       is_end;
   } hcr_cmd_type;

   // hex digit test, either case
   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
   endfunction

   // nibble value of a hex digit character
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] lc;
      logic [7:0] v;
      lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
      v  = lc - 8'h30;
      if (v > 8'd9) begin
         v = v - 8'h27;
      end
      nibble_of = v[3:0];
   endfunction

endpackage

@@ sv/hcr_front.sv @@
// front part: matches the escape pattern one byte per cycle while accept is high and issues commands
// depends on hcr_pkg
module hcr_front
   import hcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  hcr_req_type req,
   output logic        cmd_valid,
   output hcr_cmd_type cmd
);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_AMP  = 3'd1,
      PH_HASH = 3'd2,
      PH_X    = 3'd3,
      PH_D1   = 3'd4,
      PH_D2   = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] d1_ff, d1_in;
   logic [7:0] d2_ff, d2_in;

   logic       ok;
   logic       emit_c;
   logic       emit_dec;
   phase_type  nph;
   logic [7:0] c;
   logic [7:0] dec;

   assign c   = req.in_byte;
   assign dec = {nibble_of(d1_ff), nibble_of(d2_ff)};

   // pattern matcher
   always_comb begin
      ok       = 1'b0;
      emit_c   = 1'b0;
      emit_dec = 1'b0;
      nph      = phase_ff;
      d1_in    = d1_ff;
      d2_in    = d2_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            ok = 1'b1;
            if (c == CHAR_AMP) nph = PH_AMP;
            else emit_c = 1'b1;
         end
         PH_AMP: begin
            if (c == CHAR_HASH) begin
               nph = PH_HASH;
               ok  = 1'b1;
            end
         end
         PH_HASH: begin
            if (c == CHAR_X) begin
               nph = PH_X;
               ok  = 1'b1;
            end
         end
         PH_X: begin
            if (is_hex(c)) begin
               d1_in = c;
               nph   = PH_D1;
               ok    = 1'b1;
            end
         end
         PH_D1: begin
            if (is_hex(c)) begin
               d2_in = c;
               nph   = PH_D2;
               ok    = 1'b1;
            end
         end
         PH_D2: begin
            if (c == CHAR_SEMI) begin
               emit_dec = 1'b1;
               nph      = PH_IDLE;
               ok       = 1'b1;
            end
         end
         default: begin
            nph = PH_IDLE;
            ok  = 1'b1;
         end
      endcase
      if (!ok) begin
         nph = (c == CHAR_AMP) ? PH_AMP : PH_IDLE;
      end
   end

   // command build: released prefix plus optional tail byte
   always_comb begin
      cmd.digit1   = d1_in;
      cmd.digit2   = d2_in;
      cmd.is_end   = req.in_end;
      cmd.pre_cnt  = 3'd0;
      cmd.has_tail = 1'b0;
      cmd.tail     = c;
      if (!ok) begin
         cmd.pre_cnt = phase_ff;
         if (c != CHAR_AMP) begin
            cmd.has_tail = 1'b1;
         end else if (req.in_end) begin
            cmd.has_tail = 1'b1;
            cmd.tail     = CHAR_AMP;
         end
      end else begin
         cmd.has_tail = emit_c | emit_dec;
         cmd.tail     = emit_dec ? dec : c;
         if (req.in_end) begin
            cmd.pre_cnt = nph;
         end
      end
      cmd_valid = accept && (cmd.pre_cnt != 3'd0 || cmd.has_tail);
   end

   // next state, cleared at stream end
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         phase_in = req.in_end ? PH_IDLE : nph;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         d1_ff    <= 8'd0;
         d2_ff    <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         if (accept) begin
            d1_ff <= req.in_end ? 8'd0 : d1_in;
            d2_ff <= req.in_end ? 8'd0 : d2_in;
         end
      end
   end

endmodule

@@ sv/hcr_queue.sv @@
// small register queue of commands between front and back
// depends on hcr_pkg
module hcr_queue
   import hcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  hcr_cmd_type wr_cmd,
   output logic        is_full,
   output logic        head_valid,
   output hcr_cmd_type head_cmd,
   input  logic        rd_en
);

   hcr_cmd_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign is_full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) count_in = count_ff + QCNT_W'(1);
      else if (!wr_en && rd_en) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

@@ sv/hcr_back.sv @@
// back part: expands each command into its output bytes, one per cycle while the output register is free or popped
// depends on hcr_pkg
module hcr_back
   import hcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  hcr_cmd_type head_cmd,
   output logic        rd_en,
   output logic        empty,
   input  logic        pop,
   output hcr_rsp_type rsp_data
);

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   hcr_rsp_type rsp_ff;
   logic [2:0]  total;
   logic        last;
   logic        advance;
   logic [7:0]  cur_byte;

   assign total    = head_cmd.pre_cnt + 3'(head_cmd.has_tail);
   assign last     = (idx_ff == total - 3'd1);
   assign advance  = head_valid && (!valid_ff || pop);
   assign rd_en    = advance && last;
   assign empty    = !valid_ff;
   assign rsp_data = rsp_ff;

   // byte at the current position of the command
   always_comb begin
      cur_byte = head_cmd.tail;
      if (idx_ff < head_cmd.pre_cnt) begin
         case (idx_ff)
            3'd0:    cur_byte = CHAR_AMP;
            3'd1:    cur_byte = CHAR_HASH;
            3'd2:    cur_byte = CHAR_X;
            3'd3:    cur_byte = head_cmd.digit1;
            3'd4:    cur_byte = head_cmd.digit2;
            default: cur_byte = head_cmd.tail;
         endcase
      end
   end

   // position counter and output register control
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (advance) begin
         idx_in   = last ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.out_byte    <= cur_byte;
         rsp_ff.run_last    <= last;
         rsp_ff.stream_last <= last && head_cmd.is_end;
      end
   end

endmodule

@@ sv/hex_char_reference_byte_decoder.sv @@
// top level of the hex character reference byte decoder
// depends on hcr_pkg, hcr_front, hcr_queue, hcr_back
//
// Replaces every "&#x" hh ";" escape in a byte stream with the byte it encodes.
// Input channel: req_data (in_byte, in_end) is taken when push is high and full
// is low. Result channel: rsp_data is valid while empty is low and is taken
// when pop is high. Each result carries run_last on the last byte caused by one
// input transaction and stream_last on the final byte of the stream.
// The front matches one byte per cycle while full is low and writes a command to
// a 4-entry queue; the back turns each command into 1 to 6 output bytes and writes
// them one per cycle into a single output register while it is free or popped.
// A byte that releases only itself gives a one-byte command, so plain text streams
// through at one transaction per cycle while pop keeps up; its result passes a queue
// slot and then the output register. Bytes held as a possible escape produce nothing
// until it resolves; a broken pattern or an end flush releases up to 6 bytes, sent
// out one by one, and full rises when the queue fills behind such bursts. When pop
// stays low the output register holds, the queue fills, then full stalls the input.
// Synchronous reset clears the match state, the queue and the output valid flag;
// nothing is held afterwards.
module hex_char_reference_byte_decoder
   import hcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  hcr_req_type req_data,
   output logic        empty,
   input  logic        pop,
   output hcr_rsp_type rsp_data
);

   logic        accept;
   logic        cmd_valid;
   hcr_cmd_type cmd;
   logic        head_valid;
   hcr_cmd_type head_cmd;
   logic        rd_en;

   assign accept = push && !full;

   // pattern matching
   hcr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   // command queue
   hcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (cmd_valid),
      .wr_cmd     (cmd),
      .is_full    (full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .rd_en      (rd_en)
   );

   // byte expansion and output register
   hcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .rd_en      (rd_en),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

@@ sim/hex_char_reference_byte_decoder_tb.sv @@
`timescale 1ns / 1ps
// testbench for hex_char_reference_byte_decoder: queue-style driver and monitor with
// a self-contained escape-decoding predictor; depends on hcr_pkg and the decoder rtl
module hex_char_reference_byte_decoder_tb
   import hcr_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int RANDOM_ITEMS   = 288;

   // how far into the escape pattern the predictor has matched
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_AMP  = 3'd1,
      PH_HASH = 3'd2,
      PH_X    = 3'd3,
      PH_D1   = 3'd4,
      PH_D2   = 3'd5
   } match_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   hcr_req_type req_data = '0;
   logic        empty;
   logic        pop = 1'b0;
   hcr_rsp_type rsp_data;

   hcr_req_type     pending_bytes [$];
   hcr_rsp_type     expected_bytes [$];
   logic [7:0]      step_bytes [$];
   match_phase_type match_state = PH_IDLE;
   logic [7:0]      held_hi = '0;
   logic [7:0]      held_lo = '0;
   logic            req_taken = 1'b0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              queued_count = 0;
   int              bytes_in = 0;
   int              bytes_out = 0;
   int              fail_count = 0;
   int              quiet_cycles = 0;

   hex_char_reference_byte_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hex digit in either case
   function automatic logic hex_digit(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      hex_digit = (c >= "0" && c <= "9") || (folded >= "a" && folded <= "f");
   endfunction

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      if (c <= "9") begin
         v = c - "0";
      end else begin
         v = (c | 8'h20) - "a" + 8'd10;
      end
      digit_value = v[3:0];
   endfunction

   // put the held prefix bytes, oldest first, into this step's output
   task automatic release_held(input match_phase_type upto);
      if (upto >= PH_AMP) step_bytes.insert(step_bytes.size(), CHAR_AMP);
      if (upto >= PH_HASH) step_bytes.insert(step_bytes.size(), CHAR_HASH);
      if (upto >= PH_X) step_bytes.insert(step_bytes.size(), CHAR_X);
      if (upto >= PH_D1) step_bytes.insert(step_bytes.size(), held_hi);
      if (upto >= PH_D2) step_bytes.insert(step_bytes.size(), held_lo);
   endtask

   // advance the matcher by one input byte and queue the bytes it releases
   task automatic predict_decode(input hcr_req_type item);
      logic [7:0]      c;
      logic            matched;
      match_phase_type st;
      hcr_rsp_type     res;
      c = item.in_byte;
      matched = 1'b0;
      st = match_state;
      step_bytes.delete();
      case (st)
         PH_IDLE: begin
            matched = 1'b1;
            if (c == CHAR_AMP) st = PH_AMP;
            else step_bytes.insert(step_bytes.size(), c);
         end
         PH_AMP: begin
            if (c == CHAR_HASH) begin
               st = PH_HASH;
               matched = 1'b1;
            end
         end
         PH_HASH: begin
            if (c == CHAR_X) begin
               st = PH_X;
               matched = 1'b1;
            end
         end
         PH_X: begin
            if (hex_digit(c)) begin
               held_hi = c;
               st = PH_D1;
               matched = 1'b1;
            end
         end
         PH_D1: begin
            if (hex_digit(c)) begin
               held_lo = c;
               st = PH_D2;
               matched = 1'b1;
            end
         end
         default: begin
            if (c == CHAR_SEMI) begin
               step_bytes.insert(step_bytes.size(),
                                 {digit_value(held_hi), digit_value(held_lo)});
               st = PH_IDLE;
               matched = 1'b1;
            end
         end
      endcase
      // broken pattern: let the prefix go, then retry this byte as a fresh start
      if (!matched) begin
         release_held(st);
         if (c == CHAR_AMP) begin
            st = PH_AMP;
         end else begin
            step_bytes.insert(step_bytes.size(), c);
            st = PH_IDLE;
         end
      end
      // end of stream flushes whatever is still held
      if (item.in_end) begin
         release_held(st);
         st = PH_IDLE;
         held_hi = '0;
         held_lo = '0;
      end
      match_state = st;
      for (int i = 0; i < step_bytes.size(); i++) begin
         res.out_byte    = step_bytes[i];
         res.run_last    = (i == step_bytes.size() - 1);
         res.stream_last = item.in_end && (i == step_bytes.size() - 1);
         expected_bytes.insert(expected_bytes.size(), res);
      end
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic e);
      hcr_req_type item;
      item.in_byte = b;
      item.in_end  = e;
      pending_bytes.insert(pending_bytes.size(), item);
      queued_count = queued_count + 1;
   endtask

   task automatic queue_text(input string s, input logic end_last);
      for (int i = 0; i < s.len(); i++) begin
         queue_byte(s[i], end_last && (i == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] random_hex();
      string hex_set;
      hex_set = "0123456789abcdefABCDEF";
      random_hex = hex_set[$urandom_range(21)];
   endfunction

   // bytes near the pattern, with a share of fully random ones
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(6))
         0: noise_byte = CHAR_AMP;
         1: noise_byte = CHAR_HASH;
         2: noise_byte = CHAR_X;
         3: noise_byte = "X";
         4: noise_byte = CHAR_SEMI;
         5: noise_byte = random_hex();
         default: noise_byte = 8'($urandom_range(255));
      endcase
   endfunction

   // mostly escapes with random digits, some damaged or cut, plus text and noise
   task automatic queue_random_mix(input int count);
      int         first;
      int         kind;
      int         cut;
      int         n;
      logic       close_stream;
      logic [7:0] pat [0:5];
      first = queued_count;
      while (queued_count - first < count) begin
         kind = $urandom_range(99);
         close_stream = ($urandom_range(9) == 0);
         if (kind < 60) begin
            pat[0] = CHAR_AMP;
            pat[1] = CHAR_HASH;
            pat[2] = CHAR_X;
            pat[3] = random_hex();
            pat[4] = random_hex();
            pat[5] = CHAR_SEMI;
            cut = 6;
            if ($urandom_range(3) == 0) pat[$urandom_range(5)] = noise_byte();
            if ($urandom_range(7) == 0) cut = $urandom_range(1, 5);
            for (int k = 0; k < cut; k++) begin
               queue_byte(pat[k], close_stream && (k == cut - 1));
            end
         end else if (kind < 85) begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
               queue_byte(8'($urandom_range(255)), close_stream && (k == n - 1));
            end
         end else begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) begin
               queue_byte(noise_byte(), close_stream && (k == n - 1));
            end
         end
      end
   endtask

   // driver: hold a presented transaction until taken, idle and stall at random
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
         pop  <= 1'b0;
      end else begin
         if (req_taken) void'(pending_bytes.pop_front());
         if (push && !req_taken) begin
            push <= 1'b1;
         end else if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            push     <= 1'b1;
            req_data <= pending_bytes[0];
         end else begin
            push <= 1'b0;
         end
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: predict on accepted input, check accepted output, watch for a hang
   always @(posedge clock) begin : monitor
      hcr_rsp_type want;
      logic        rsp_taken;
      req_taken = !reset && push && !full;
      rsp_taken = !reset && pop && !empty;
      if (req_taken) begin
         predict_decode(req_data);
         bytes_in = bytes_in + 1;
      end
      if (rsp_taken) begin
         bytes_out = bytes_out + 1;
         if (expected_bytes.size() == 0) begin
            $error("unexpected output byte %02h", rsp_data.out_byte);
            fail_count = fail_count + 1;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_data.out_byte);
               fail_count = fail_count + 1;
            end
            if (rsp_data.run_last !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_data.run_last);
               fail_count = fail_count + 1;
            end
            if (rsp_data.stream_last !== want.stream_last) begin
               $error("stream_last: expected %0b, got %0b", want.stream_last,
                      rsp_data.stream_last);
               fail_count = fail_count + 1;
            end
         end
      end
      if (req_taken || rsp_taken) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // sender rarely idle, receiver mostly stalled
      send_idle_pct = 12;
      recv_idle_pct = 65;
      // extremes of the byte as plain text
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      // full escape with a lower-case digit
      queue_text("&#x4a;", 1'b0);
      // upper-case X breaks the pattern
      queue_text("&#X", 1'b0);
      // broken after both digits: six bytes from one input
      queue_text("&#x12q", 1'b0);
      // escape completed on the final byte of a stream
      queue_text("&#xA0;", 1'b1);
      // lone start flushed by the end of stream
      queue_text("&", 1'b1);
      queue_random_mix(RANDOM_ITEMS / 3);
      wait (pending_bytes.size() == 0);

      // the other way round
      send_idle_pct = 65;
      recv_idle_pct = 12;
      queue_random_mix(RANDOM_ITEMS / 3);
      wait (pending_bytes.size() == 0);

      // neither side idles
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_mix(RANDOM_ITEMS / 3);
      queue_byte(8'($urandom_range(255)), 1'b1);
      wait (pending_bytes.size() == 0);
      wait (expected_bytes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("decoded %0d input bytes into %0d output bytes", bytes_in, bytes_out);
      $display("covered escapes, broken prefixes and stream ends under three stall mixes");
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
